>>> hw/rtl/box_mean_filter_rgb_defines.svh
// Assertion macros for the box mean filter.
`ifndef BOX_MEAN_FILTER_RGB_DEFINES_SVH
`define BOX_MEAN_FILTER_RGB_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMF_ASSERT_NOW(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("box mean filter check failed");
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("box mean filter check failed");
`else
`define BMF_ASSERT_NOW(lbl, clk, rst_n, cond)
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> hw/rtl/bmf_pkg.sv
`default_nettype none
package bmf_pkg;
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_RADIUS_DEF = 7;
    localparam int ROW_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 10;
    localparam int LANES          = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

    localparam logic [1:0] MODE_HORIZ = 2'd1;
    localparam logic [1:0] MODE_VERT  = 2'd2;
    localparam logic       KIND_PIXEL = 1'b0;

    localparam logic [2:0]       RADIUS_RST = 3'd3;
    localparam logic [1:0]       MODE_RST   = 2'd0;
    localparam logic [ROW_W-1:0] WIDTH_RST  = 10'd512;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 10'd512;

    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
    } lane_ctrl_t;
endpackage
`default_nettype wire

>>> hw/rtl/bmf_lane.sv
`default_nettype none
// One color channel: window accumulator followed by a restoring divider.
module bmf_lane import bmf_pkg::*;
#(
    parameter int SW = 18,
    parameter int CW = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lane_ctrl_t    ctrl,
    input  wire logic [7:0]    sample,
    input  wire logic [CW-1:0] divisor,
    output logic [7:0]         quot,
    output logic               done
);
    localparam int KW = $clog2(SW + 1);

    logic [SW-1:0] acc_reg;
    logic [SW-1:0] q_reg;
    logic [CW-1:0] rem_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW:0]   rem_shift;
    logic          fits;

    assign rem_shift = {rem_reg, q_reg[SW-1]};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.clear)
                acc_reg <= '0;
            else if (ctrl.acc)
                acc_reg <= acc_reg + SW'(sample);
            if (ctrl.start)
            begin
                q_reg    <= acc_reg;
                rem_reg  <= '0;
                cnt_reg  <= KW'(SW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[SW-2:0], fits};
                rem_reg <= fits ? CW'(rem_shift - {1'b0, divisor}) : CW'(rem_shift);
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg[7:0];
    assign done = done_reg;
endmodule
`default_nettype wire

>>> hw/rtl/bmf_out.sv
`default_nettype none
// Merges the lane quotients into one output beat and holds it until taken.
module bmf_out import bmf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [LANES-1:0][7:0] lane_q,
    input  wire logic                  last,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic                       frame_end,
    output logic                       free
);
    logic       valid_reg;
    logic [7:0] r_reg, g_reg, b_reg;
    logic       last_reg;

    assign free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_reg    <= lane_q[0];
            g_reg    <= lane_q[1];
            b_reg    <= lane_q[2];
            last_reg <= last;
        end
    end

    assign out_valid = valid_reg;
    assign red_out   = r_reg;
    assign green_out = g_reg;
    assign blue_out  = b_reg;
    assign frame_end = last_reg;
endmodule
`default_nettype wire

>>> hw/rtl/box_mean_filter_rgb.sv
`default_nettype none
// Channel | Signals                                  | Direction
// in      | in_valid, in_stall, kind, red/green/blue_in | sink
// out     | out_valid, out_stall, red/green/blue_out, frame_end | source
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
// One item at a time. An item with a result passes the sum, drain, start,
// divide and load steps: sum reads N taps, the divider produces SW bits;
// N = window pixel count (one line store read per cycle), SW = sum width, 16 by
// default (one divider bit per cycle, three lanes).
// Reset sets config defaults and clears counters; the line store holds no reset.
// A stalled output beat holds; a following result waits in the load step.
module box_mean_filter_rgb import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  kind,
    input  wire logic [7:0]            red_in,
    input  wire logic [7:0]            green_in,
    input  wire logic [7:0]            blue_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
`include "box_mean_filter_rgb_defines.svh"

    localparam int SL  = 2 * MAX_RADIUS + 2;
    localparam int SLW = $clog2(SL);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int DW  = RW + 1;
    localparam int NW  = WW + ROW_W + 1;
    localparam int CW  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SW  = $clog2(255 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_CHK, S_SUM, S_DRAIN, S_START, S_DIV, S_LOAD
    } state_t;

    state_t           state_reg;
    logic [2:0]       radius_reg;
    logic [1:0]       mode_reg;
    logic [ROW_W-1:0] width_reg, height_reg;
    logic             kind_reg;
    logic [23:0]      pix_reg;
    logic [XW-1:0]    in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [SLW-1:0]   in_slot_reg, out_slot_reg;
    logic [NW-1:0]    rcv_reg, oidx_reg, delay_reg;
    logic [CW-1:0]    count_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic             rd_vld_reg;
    logic [23:0]      rd_data_reg;
    logic [23:0]      mem [SL][MAX_WIDTH];

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [RW-1:0]    r_eff, rx, ry;
    logic signed [DW-1:0] rx_s, ry_s;
    logic             cfg_acc, in_acc, pix_ok, flush_emit, emit_chk, last_tap;
    logic             mem_we, load, out_free, last;
    logic signed [XW+1:0]    cx;
    logic signed [ROW_W+1:0] cy, dly;
    logic signed [SLW+1:0]   slot_s;
    logic [XW-1:0]    rd_x;
    logic [ROW_W-1:0] rd_y;
    logic [SLW-1:0]   rd_slot;
    logic [XW-1:0]    out_col_next;
    logic [ROW_W-1:0] out_row_next;
    lane_ctrl_t       lane_ctrl;
    logic [LANES-1:0][7:0] lane_q;
    logic [LANES-1:0] lane_done;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        rx = (mode_reg == MODE_VERT) ? '0 : r_eff;
        ry = (mode_reg == MODE_HORIZ) ? '0 : r_eff;
    end

    assign rx_s = $signed({1'b0, rx});
    assign ry_s = $signed({1'b0, ry});

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign in_acc    = in_valid && !in_stall;

    assign pix_ok     = (kind_reg == KIND_PIXEL) && (in_row_reg < h_eff);
    assign flush_emit = !pix_ok && (in_row_reg >= h_eff) && (out_row_reg < h_eff);
    assign emit_chk   = (oidx_reg + delay_reg) < rcv_reg;
    assign mem_we     = (state_reg == S_UPD) && pix_ok;
    assign last_tap   = (dx_reg == rx_s) && (dy_reg == ry_s);

    // window tap address, clamped to the frame edge
    always_comb
    begin
        cx = $signed({2'b00, out_col_reg}) + (XW+2)'(dx_reg);
        if (cx < 0)
            rd_x = '0;
        else if (cx >= $signed((XW+2)'(w_eff)))
            rd_x = XW'(w_eff - 1'b1);
        else
            rd_x = XW'(cx);
        cy = $signed({2'b00, out_row_reg}) + (ROW_W+2)'(dy_reg);
        if (cy < 0)
            rd_y = '0;
        else if (cy >= $signed((ROW_W+2)'(h_eff)))
            rd_y = h_eff - 1'b1;
        else
            rd_y = ROW_W'(cy);
        dly    = $signed({2'b00, rd_y}) - $signed({2'b00, out_row_reg});
        slot_s = $signed({2'b00, out_slot_reg}) + (SLW+2)'(dly);
        if (slot_s < 0)
            rd_slot = SLW'(slot_s + (SLW+2)'(SL));
        else if (slot_s >= (SLW+2)'(SL))
            rd_slot = SLW'(slot_s - (SLW+2)'(SL));
        else
            rd_slot = SLW'(slot_s);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[in_slot_reg][in_col_reg] <= pix_reg;
        rd_data_reg <= mem[rd_slot][rd_x];
    end

    always_comb
    begin
        out_col_next = out_col_reg + 1'b1;
        out_row_next = out_row_reg;
        if (WW'(out_col_reg) + 1'b1 >= w_eff)
        begin
            out_col_next = '0;
            out_row_next = out_row_reg + 1'b1;
        end
    end

    assign last = out_row_next >= h_eff;
    assign load = (state_reg == S_LOAD) && out_free;

    assign lane_ctrl.clear = ((state_reg == S_UPD) && flush_emit) ||
                             ((state_reg == S_CHK) && emit_chk);
    assign lane_ctrl.acc   = rd_vld_reg;
    assign lane_ctrl.start = (state_reg == S_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            radius_reg   <= RADIUS_RST;
            mode_reg     <= MODE_RST;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            kind_reg     <= KIND_PIXEL;
            pix_reg      <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            rcv_reg      <= '0;
            oidx_reg     <= '0;
            delay_reg    <= '0;
            count_reg    <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == S_SUM);
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        case (cfg_index)
                            CFG_RADIUS: radius_reg <= cfg_data[2:0];
                            CFG_MODE:   mode_reg   <= cfg_data[1:0];
                            CFG_WIDTH:  width_reg  <= cfg_data;
                            CFG_HEIGHT: height_reg <= cfg_data;
                            default: ;
                        endcase
                        if (cfg_index <= CFG_HEIGHT)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                            rcv_reg      <= '0;
                            oidx_reg     <= '0;
                        end
                    end
                    else if (in_acc)
                    begin
                        kind_reg  <= kind;
                        pix_reg   <= {red_in, green_in, blue_in};
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    delay_reg <= NW'(r_eff) * NW'(w_eff) + NW'(r_eff);
                    count_reg <= CW'({rx, 1'b1}) * CW'({ry, 1'b1});
                    dx_reg    <= -rx_s;
                    dy_reg    <= -ry_s;
                    if (pix_ok)
                    begin
                        rcv_reg <= rcv_reg + 1'b1;
                        if (WW'(in_col_reg) + 1'b1 >= w_eff)
                        begin
                            in_col_reg  <= '0;
                            in_row_reg  <= in_row_reg + 1'b1;
                            in_slot_reg <= (in_slot_reg == SLW'(SL - 1)) ? '0
                                                                         : in_slot_reg + 1'b1;
                        end
                        else
                            in_col_reg <= in_col_reg + 1'b1;
                        state_reg <= S_CHK;
                    end
                    else if (flush_emit)
                        state_reg <= S_SUM;
                    else
                        state_reg <= S_IDLE;
                end
                S_CHK:
                    state_reg <= emit_chk ? S_SUM : S_IDLE;
                S_SUM:
                begin
                    if (last_tap)
                        state_reg <= S_DRAIN;
                    else if (dx_reg == rx_s)
                    begin
                        dx_reg <= -rx_s;
                        dy_reg <= dy_reg + 1'b1;
                    end
                    else
                        dx_reg <= dx_reg + 1'b1;
                end
                S_DRAIN:
                    state_reg <= S_START;
                S_START:
                    state_reg <= S_DIV;
                S_DIV:
                    if (lane_done[0])
                        state_reg <= S_LOAD;
                S_LOAD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (last)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                            rcv_reg      <= '0;
                            oidx_reg     <= '0;
                        end
                        else
                        begin
                            out_col_reg <= out_col_next;
                            out_row_reg <= out_row_next;
                            oidx_reg    <= oidx_reg + 1'b1;
                            if (out_row_next != out_row_reg)
                                out_slot_reg <= (out_slot_reg == SLW'(SL - 1)) ? '0
                                                                               : out_slot_reg + 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bmf_lane #(
            .SW(SW),
            .CW(CW)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (lane_ctrl),
            .sample  (rd_data_reg[23-8*i -: 8]),
            .divisor (count_reg),
            .quot    (lane_q[i]),
            .done    (lane_done[i])
        );
    end

    bmf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .lane_q    (lane_q),
        .last      (last),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end),
        .free      (out_free)
    );

    `BMF_ASSERT_NOW(a_lanes_in_step, clk, rst_n, (lane_done == '0) || (&lane_done))
    `BMF_ASSERT_NOW(a_no_cfg_with_item, clk, rst_n, !(cfg_acc && in_acc))
    `BMF_ASSERT_NEXT(a_beat_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(red_out))
    `BMF_ASSERT_NEXT(a_load_only_free, clk, rst_n, (state_reg == S_LOAD) && !out_free, state_reg == S_LOAD)
endmodule
`default_nettype wire

>>> verif/box_mean_filter_rgb_test.sv
`default_nettype none
module box_mean_filter_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bmf_pkg::*;

    localparam logic       KIND_FLUSH  = ~KIND_PIXEL;
    localparam logic [1:0] MODE_SQUARE = 2'd0;
    localparam logic [1:0] MODE_ALT    = 2'd3;  // unused code, behaves as square
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int RING       = 2 * MAX_RADIUS_DEF + 2;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 300;
    localparam int ITEM_GOAL  = 1850;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } mean_pix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = KIND_PIXEL;
    logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] red_out, green_out, blue_out;
    logic frame_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_mean_filter_rgb dut (.*);

    always #5 clk = ~clk;

    // shadow state of the filter
    logic [23:0] shadow_lines [RING][MAX_WIDTH_DEF];
    int unsigned reg_radius = RADIUS_RST, reg_mode = MODE_RST;
    int unsigned reg_width = WIDTH_RST, reg_height = HEIGHT_RST;
    int unsigned in_col, in_row, out_col, out_row;

    mean_pix_t expected_means[$];
    int errors, items, results, reg_writes, quiet_run;

    function automatic int unsigned width_eff();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return reg_width;
    endfunction

    function automatic int unsigned height_eff();
        return (reg_height == 0) ? 1 : reg_height;
    endfunction

    function automatic void restart_counts();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function automatic void push_mean();
        int unsigned w, h, cnt, yy, xx;
        int rx, ry, y, x;
        int unsigned sum [3];
        mean_pix_t m;
        w = width_eff();
        h = height_eff();
        rx = reg_radius;
        ry = reg_radius;
        if (reg_mode == MODE_HORIZ) ry = 0;
        else if (reg_mode == MODE_VERT) rx = 0;
        sum = '{0, 0, 0};
        for (int dy = -ry; dy <= ry; dy++)
        begin
            y = int'(out_row) + dy;
            yy = (y < 0) ? 0 : (y >= int'(h)) ? h - 1 : y;
            for (int dx = -rx; dx <= rx; dx++)
            begin
                x = int'(out_col) + dx;
                xx = (x < 0) ? 0 : (x >= int'(w)) ? w - 1 : x;
                sum[0] += shadow_lines[yy % RING][xx][23:16];
                sum[1] += shadow_lines[yy % RING][xx][15:8];
                sum[2] += shadow_lines[yy % RING][xx][7:0];
            end
        end
        cnt = (2 * rx + 1) * (2 * ry + 1);
        m.red = 8'(sum[0] / cnt);
        m.green = 8'(sum[1] / cnt);
        m.blue = 8'(sum[2] / cnt);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        m.last = out_row >= h;
        if (m.last) restart_counts();
        expected_means.push_back(m);
    endfunction

    function automatic void model_beat(logic k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, rad;
        w = width_eff();
        h = height_eff();
        rad = reg_radius;
        if (k == KIND_PIXEL && in_row < h)
        begin
            shadow_lines[in_row % RING][in_col] = {r, g, b};
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (out_row * w + out_col + rad * w + rad < in_row * w + in_col) push_mean();
        end
        else if (in_row >= h && out_row < h)
            push_mean();
    endfunction

    function automatic int pick_gap();
        int p;
        if (quiet_run > 0)
        begin
            quiet_run--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3) quiet_run = $urandom_range(20, 80);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall <= ~out_stall;
            stall_left <= out_stall ? $urandom_range(0, 30) : pick_gap();
        end
    end

    always @(posedge clk)
    begin
        mean_pix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results++;
            if (expected_means.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat r=%0d g=%0d b=%0d end=%0b",
                         $time, red_out, green_out, blue_out, frame_end);
            end
            else
            begin
                want = expected_means.pop_front();
                if (red_out !== want.red)
                begin
                    errors++;
                    $display("%0t: red expected %0d got %0d", $time, want.red, red_out);
                end
                if (green_out !== want.green)
                begin
                    errors++;
                    $display("%0t: green expected %0d got %0d", $time, want.green, green_out);
                end
                if (blue_out !== want.blue)
                begin
                    errors++;
                    $display("%0t: blue expected %0d got %0d", $time, want.blue, blue_out);
                end
                if (frame_end !== want.last)
                begin
                    errors++;
                    $display("%0t: frame_end expected %0b got %0b", $time, want.last,
                             frame_end);
                end
            end
        end
    end

    int idle_cycles;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress, %0d beats outstanding", $time, expected_means.size());
            $display("box_mean_filter_rgb regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do @(posedge clk); while (in_stall);
        model_beat(k, r, g, b);
        items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pixel();
        send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_RADIUS: reg_radius = 32'(data[2:0]);
            CFG_MODE:   reg_mode = 32'(data[1:0]);
            CFG_WIDTH:  reg_width = 32'(data);
            CFG_HEIGHT: reg_height = 32'(data);
            default: return;
        endcase
        restart_counts();
    endtask

    // upper data bits are junk for the narrow registers
    task automatic set_shape(int unsigned rad, logic [1:0] mode, int unsigned w, int unsigned h);
        write_reg(CFG_RADIUS, {7'($urandom_range(0, 127)), rad[2:0]});
        write_reg(CFG_MODE, {8'($urandom_range(0, 255)), mode});
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic finish_frame();
        while (in_row >= height_eff())
            if ($urandom_range(0, 9) == 0) send_pixel();
            else send_item(KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic full_frame();
        repeat (width_eff() * height_eff())
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(KIND_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            send_pixel();
        end
        finish_frame();
    endtask

    task automatic test_directed();
        set_shape(1, MODE_SQUARE, 4, 3);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);   // nothing pending
        send_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(KIND_FLUSH, 8'hff, 8'hff, 8'hff);   // frame not complete
        send_item(KIND_PIXEL, 8'hff, 8'h00, 8'hff);
        send_item(KIND_PIXEL, 8'h00, 8'hff, 8'h00);
        repeat (8) send_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);   // dropped, acts as a flush
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        finish_frame();
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);   // idle after frame end
        write_reg(CFG_UNUSED, 10'h3ff);               // no effect
        full_frame();
    endtask

    task automatic test_reg_extremes();
        set_shape(0, MODE_SQUARE, 1, 1);
        repeat (3) full_frame();
        set_shape(7, MODE_HORIZ, 64, 1);
        full_frame();
        set_shape(7, MODE_VERT, 1, 512);
        full_frame();
        set_shape(7, MODE_SQUARE, 9, 8);
        full_frame();
        set_shape(2, MODE_ALT, 0, 0);                 // zero size reads as one
        full_frame();
        set_shape(0, MODE_HORIZ, 1023, 1);            // width clamps to the maximum
        full_frame();
        set_shape(0, MODE_VERT, 512, 512);
        repeat (20) send_pixel();                     // broken frame, reset by next write
    endtask

    task automatic test_random_frames();
        int unsigned rad, w, h;
        logic [1:0] mode;
        while (items < ITEM_GOAL)
        begin
            mode = 2'($urandom_range(0, 3));
            rad = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            if (rad > 3 && (mode == MODE_SQUARE || mode == MODE_ALT))
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            set_shape(rad, mode, w, h);
            repeat ($urandom_range(1, 3)) full_frame();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, w * h)) send_pixel();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_reg_extremes();
        test_random_frames();
        drain();
        $display("%0d input beats, %0d output beats checked, %0d register writes",
                 items, results, reg_writes);
        $display("windows: square, horizontal, vertical; radius 0..7; sizes 1..512");
        if (errors == 0)
            $display("box_mean_filter_rgb regression: pass");
        else
            $display("box_mean_filter_rgb regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_lane.sv
hw/rtl/bmf_out.sv
hw/rtl/box_mean_filter_rgb.sv
verif/box_mean_filter_rgb_test.sv
